FILE: rtl/selectable_lowpass_fir_filter_unit_assert.svh
// Assertion macros for the checker file of the filter block.
`ifndef SELECTABLE_LOWPASS_FIR_FILTER_UNIT_ASSERT_SVH
`define SELECTABLE_LOWPASS_FIR_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SLFIR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slfir: same-cycle property violated");

// Next-cycle implication, sampled on the rising clock edge.
`define SLFIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slfir: next-cycle property violated");

`endif

FILE: rtl/slfir_pkg.sv
`default_nettype none

package slfir_pkg;

   // Field widths
   localparam int SAMPLE_W    = 32;
   localparam int ALPHA_W     = 17;
   localparam int COEF_W      = 18;
   localparam int FRAC_W      = 16;
   localparam int MAX_TAPS    = 4;
   localparam int SEEN_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   // Arithmetic widths: full product, truncated term, FIR and low-pass sums
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int TERM_W    = PROD_W - FRAC_W;
   localparam int FIR_SUM_W = TERM_W + 2;
   localparam int LP_SUM_W  = TERM_W + 1;

   // Constants
   localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 17'd65536;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 17'd32768;
   localparam logic [COEF_W-1:0]  COEF0_RESET  = 18'd65536;
   localparam logic [SEEN_W-1:0]  SEEN_FULL    = 2'd3;
   localparam logic               MODE_LOW_PASS = 1'b0;
   localparam logic               MODE_FIR      = 1'b1;

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FILTER_MODE     = 3'd0,
      REG_SMOOTHING_ALPHA = 3'd1,
      REG_TAP_COEF_0      = 3'd2,
      REG_TAP_COEF_1      = 3'd3,
      REG_TAP_COEF_2      = 3'd4,
      REG_TAP_COEF_3      = 3'd5
   } csr_index_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic                              filter_mode;
      logic [ALPHA_W-1:0]                smoothing_alpha;
      logic [MAX_TAPS-1:0][COEF_W-1:0]   tap_coef;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/slfir_csr.sv
`default_nettype none

module slfir_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 wr_en,
   input  wire logic [slfir_pkg::CSR_INDEX_W-1:0]    wr_index,
   input  wire logic [slfir_pkg::CSR_DATA_W-1:0]     wr_data,
   output slfir_pkg::cfg_type                        cfg
);

   slfir_pkg::cfg_type cfg_ff, cfg_in;

   // Register decode; unknown indexes leave everything as is
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (slfir_pkg::csr_index_type'(wr_index))
            slfir_pkg::REG_FILTER_MODE:     cfg_in.filter_mode = wr_data[0];
            slfir_pkg::REG_SMOOTHING_ALPHA:
               cfg_in.smoothing_alpha = wr_data[slfir_pkg::ALPHA_W-1:0];
            slfir_pkg::REG_TAP_COEF_0:      cfg_in.tap_coef[0] = wr_data;
            slfir_pkg::REG_TAP_COEF_1:      cfg_in.tap_coef[1] = wr_data;
            slfir_pkg::REG_TAP_COEF_2:      cfg_in.tap_coef[2] = wr_data;
            slfir_pkg::REG_TAP_COEF_3:      cfg_in.tap_coef[3] = wr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_mode     <= slfir_pkg::MODE_LOW_PASS;
         cfg_ff.smoothing_alpha <= slfir_pkg::ALPHA_RESET;
         cfg_ff.tap_coef[0]     <= slfir_pkg::COEF0_RESET;
         cfg_ff.tap_coef[1]     <= '0;
         cfg_ff.tap_coef[2]     <= '0;
         cfg_ff.tap_coef[3]     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/slfir_core.sv
`default_nettype none

module slfir_core #(
   parameter int TAPS = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  fire,
   input  wire logic signed [slfir_pkg::SAMPLE_W-1:0] sample_in,
   input  wire logic                                  start_of_sequence,
   input  slfir_pkg::cfg_type                         cfg,
   output logic signed [slfir_pkg::SAMPLE_W-1:0]      sample_out,
   output logic                                       saturated
);

   localparam int DL_DEPTH = (TAPS > 1) ? TAPS - 1 : 1;
   localparam int SW       = slfir_pkg::SAMPLE_W;
   localparam int PW       = slfir_pkg::PROD_W;
   localparam int TW       = slfir_pkg::TERM_W;
   localparam int FW       = slfir_pkg::FIR_SUM_W;
   localparam int LW       = slfir_pkg::LP_SUM_W;
   localparam int AW       = slfir_pkg::ALPHA_W;
   localparam int NW       = slfir_pkg::SEEN_W;
   localparam logic signed [FW-1:0] OUT_MAX = FW'(64'sh7FFFFFFF);
   localparam logic signed [FW-1:0] OUT_MIN = FW'(-64'sh80000000);

   // Filter history
   logic signed [SW-1:0] prev_out_ff, prev_out_in;
   logic signed [SW-1:0] prev_in_ff, prev_in_in;
   logic signed [SW-1:0] dl_ff [DL_DEPTH];
   logic signed [SW-1:0] dl_in [DL_DEPTH];
   logic [NW-1:0]        seen_ff, seen_in;

   // Clamp a wide sum to the sample range
   function automatic logic signed [SW-1:0] clamp(input logic signed [FW-1:0] v);
      logic signed [SW-1:0] r;
      if (v > OUT_MAX)      r = OUT_MAX[SW-1:0];
      else if (v < OUT_MIN) r = OUT_MIN[SW-1:0];
      else                  r = v[SW-1:0];
      return r;
   endfunction

   // Low-pass path
   logic [AW-1:0]        alpha_eff, alpha_rest;
   logic signed [SW-1:0] lp_y_prev, lp_x_prev, pair_avg;
   logic signed [SW:0]   pair_sum;
   logic signed [PW-1:0] hold_prod, new_prod;
   logic signed [LW-1:0] lp_sum;
   logic signed [SW-1:0] lp_clamped;

   always_comb begin
      alpha_eff  = (cfg.smoothing_alpha > slfir_pkg::ALPHA_ONE) ?
                   slfir_pkg::ALPHA_ONE : cfg.smoothing_alpha;
      alpha_rest = slfir_pkg::ALPHA_ONE - alpha_eff;
      lp_y_prev  = start_of_sequence ? sample_in : prev_out_ff;
      lp_x_prev  = start_of_sequence ? sample_in : prev_in_ff;
      pair_sum   = {sample_in[SW-1], sample_in} + {lp_x_prev[SW-1], lp_x_prev};
      pair_avg   = pair_sum[SW:1];
      hold_prod  = $signed({1'b0, alpha_rest}) * lp_y_prev;
      new_prod   = $signed({1'b0, alpha_eff}) * pair_avg;
      // arithmetic drop of the fraction bits is a floor
      lp_sum     = {hold_prod[PW-1], hold_prod[PW-1:slfir_pkg::FRAC_W]}
                 + {new_prod[PW-1], new_prod[PW-1:slfir_pkg::FRAC_W]};
      lp_clamped = clamp({lp_sum[LW-1], lp_sum});
   end

   // FIR path: one multiplier per tap, unused taps give zero
   logic [NW-1:0]        valid_hist;
   logic signed [TW-1:0] fir_term [slfir_pkg::MAX_TAPS];
   logic signed [FW-1:0] fir_sum;

   assign valid_hist = start_of_sequence ? '0 : seen_ff;

   for (genvar j = 0; j < slfir_pkg::MAX_TAPS; j++) begin : g_tap
      logic signed [SW-1:0] tap_sample;
      logic signed [PW-1:0] tap_prod;
      if (j == 0) begin : g_cur
         assign tap_sample = sample_in;
      end else if (j < TAPS) begin : g_hist
         assign tap_sample = (NW'(j) <= valid_hist) ? dl_ff[j-1] : '0;
      end else begin : g_off
         assign tap_sample = '0;
      end
      assign tap_prod    = $signed(cfg.tap_coef[j]) * tap_sample;
      assign fir_term[j] = (j < TAPS) ? tap_prod[PW-1:slfir_pkg::FRAC_W] : '0;
   end

   always_comb begin
      fir_sum = '0;
      for (int k = 0; k < slfir_pkg::MAX_TAPS; k++) begin
         fir_sum = fir_sum + FW'(fir_term[k]);
      end
   end

   // Mode select and output saturation
   logic signed [FW-1:0] y_wide;

   always_comb begin
      y_wide     = (cfg.filter_mode == slfir_pkg::MODE_FIR) ? fir_sum : FW'(lp_sum);
      sample_out = clamp(y_wide);
      saturated  = (y_wide > OUT_MAX) || (y_wide < OUT_MIN);
   end

   // History update when an item is processed
   always_comb begin
      prev_out_in = prev_out_ff;
      prev_in_in  = prev_in_ff;
      seen_in     = seen_ff;
      for (int k = 0; k < DL_DEPTH; k++) begin
         dl_in[k] = dl_ff[k];
      end
      if (fire) begin
         prev_out_in = lp_clamped;
         prev_in_in  = sample_in;
         seen_in     = (valid_hist == slfir_pkg::SEEN_FULL) ?
                       slfir_pkg::SEEN_FULL : valid_hist + NW'(1);
         dl_in[0]    = sample_in;
         for (int k = 1; k < DL_DEPTH; k++) begin
            dl_in[k] = dl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_out_ff <= '0;
         prev_in_ff  <= '0;
         seen_ff     <= '0;
         for (int k = 0; k < DL_DEPTH; k++) begin
            dl_ff[k] <= '0;
         end
      end else begin
         prev_out_ff <= prev_out_in;
         prev_in_ff  <= prev_in_in;
         seen_ff     <= seen_in;
         for (int k = 0; k < DL_DEPTH; k++) begin
            dl_ff[k] <= dl_in[k];
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/selectable_lowpass_fir_filter_unit.sv
// Selectable low-pass / FIR sample filter.
// req channel: one signed Q16.16 sample per transfer on req_tdata, with
// req_tuser[0] set on the first sample of a sequence (clears the history).
// rsp channel: one filtered Q16.16 sample per accepted input on rsp_tdata,
// rsp_tuser[0] set when the result was clamped to the 32-bit range.
// csr channel: register writes (index, data), always ready; write only while
// no sample is in flight. Index 0 mode, 1 alpha, 2..5 tap coefficients.
// Pipeline: a sample taken into the input register is filtered and held in the
// result register, from which it is offered on rsp. Throughput: one sample per
// cycle while rsp is ready; the low-pass feedback through the alpha multipliers
// and the sum closes in the compute stage.
// Stalls: while rsp_tready is low the result is held; one more sample is
// taken into the input register, then req_tready drops until rsp drains.
// Reset: clears configuration to its defaults, the filter history, and both
// pipeline valid bits; no clearing pass is needed.
`default_nettype none

module selectable_lowpass_fir_filter_unit #(
   parameter int TAPS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input samples
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [31:0]                         req_tdata,  // sample_in
   input  wire logic [0:0]                          req_tuser,  // start_of_sequence
   // results
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [31:0]                              rsp_tdata,  // sample_out
   output logic [0:0]                               rsp_tuser,  // saturated
   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [slfir_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [slfir_pkg::CSR_DATA_W-1:0]    csr_data
);

   slfir_pkg::cfg_type cfg;

   assign csr_ready = 1'b1;

   slfir_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Pipeline control
   logic        in_valid_ff, in_valid_in;
   logic        out_valid_ff, out_valid_in;
   logic        req_xfer, advance;

   logic signed [31:0] in_sample_ff;
   logic               in_start_ff;
   logic signed [31:0] out_sample_ff;
   logic               out_sat_ff;
   logic signed [31:0] core_sample;
   logic               core_sat;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_sample_ff <= req_tdata;
         in_start_ff  <= req_tuser[0];
      end
   end

   slfir_core #(.TAPS(TAPS)) u_core (
      .clock             (clock),
      .reset             (reset),
      .fire              (advance),
      .sample_in         (in_sample_ff),
      .start_of_sequence (in_start_ff),
      .cfg               (cfg),
      .sample_out        (core_sample),
      .saturated         (core_sat)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_ff <= core_sample;
         out_sat_ff    <= core_sat;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_sample_ff;
   assign rsp_tuser[0] = out_sat_ff;

endmodule

`default_nettype wire

FILE: rtl/slfir_checker.sv
`default_nettype none

`include "selectable_lowpass_fir_filter_unit_assert.svh"

module slfir_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [31:0]                         rsp_tdata,
   input wire logic [0:0]                          rsp_tuser
);

   // a stalled result stays offered
   `SLFIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // a saturated result sits at one of the two rails
   `SLFIR_ASSERT_IMPLY(a_sat_rail, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == 32'h7FFFFFFF || rsp_tdata == 32'h80000000)

   // reset empties the result stage
   `SLFIR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // input back-pressure only comes from a full, stalled result stage
   `SLFIR_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)

endmodule

bind selectable_lowpass_fir_filter_unit slfir_checker u_checker (.*);

`default_nettype wire

FILE: tb/sv/selectable_lowpass_fir_filter_unit_tb.sv
`timescale 1ns / 1ps

module selectable_lowpass_fir_filter_unit_tb;
   import slfir_pkg::*;

   localparam int FIR_TAPS      = 4;
   localparam int IDLE_LIMIT    = 4000;   // cycles without any transfer
   localparam int SETTLE_CYCLES = 8;      // pipeline is two stages deep
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 125;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_NEG1 = 32'hFFFF_FFFF;
   localparam logic [COEF_W-1:0]   COEF_MAX = 18'h1_FFFF;
   localparam logic [COEF_W-1:0]   COEF_MIN = 18'h2_0000;
   localparam logic [ALPHA_W-1:0]  ALPHA_TOP = 17'h1_FFFF;

   localparam longint OUT_MAX = 64'sd2147483647;
   localparam longint OUT_MIN = -64'sd2147483648;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                sos;
   } sample_item_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                sat;
   } filtered_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata = '0;   // sample_in
   logic [0:0]             req_tuser = '0;   // start_of_sequence
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;        // sample_out
   logic [0:0]             rsp_tuser;        // saturated
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   selectable_lowpass_fir_filter_unit #(.TAPS(FIR_TAPS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // queues between stimulus, driver and checker
   sample_item_type pending_samples[$];
   filtered_type    expected_outputs[$];

   int error_count = 0;
   int samples_sent = 0;
   int results_seen = 0;
   int sequences_queued = 0;
   int clamped_seen = 0;
   int csr_writes = 0;
   int holds_done = 0;
   int idle_cycles = 0;

   // filter model: configuration
   logic                     cfg_mode = MODE_LOW_PASS;
   logic [ALPHA_W-1:0]       cfg_alpha = ALPHA_RESET;
   logic signed [COEF_W-1:0] cfg_coef[MAX_TAPS] = '{COEF0_RESET, '0, '0, '0};

   // filter model: history
   longint lp_prev_out = 0;
   longint lp_prev_in = 0;
   longint fir_history[MAX_TAPS-1] = '{0, 0, 0};
   int     fir_seen = 0;

   // One filter step: both paths advance, the mode picks the result.
   function automatic filtered_type predict_filtered(input logic signed [SAMPLE_W-1:0] x_in,
                                                     input logic sos);
      longint x, a, sum, avg, lp, fir, y, tap_in;
      int hist_valid;
      filtered_type res;
      x = x_in;
      a = (cfg_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(cfg_alpha);

      // low-pass path; start of sequence seeds both histories with x
      if (sos) begin
         lp_prev_in = x;
         lp_prev_out = x;
      end
      sum = x + lp_prev_in;
      avg = sum >>> 1;
      lp = (((65536 - a) * lp_prev_out) >>> FRAC_W) + ((a * avg) >>> FRAC_W);

      // FIR path; history before the start counts as zero
      hist_valid = sos ? 0 : fir_seen;
      fir = 0;
      for (int j = 0; j < FIR_TAPS && j < MAX_TAPS; j++) begin
         if (j == 0)
            tap_in = x;
         else if (j <= hist_valid)
            tap_in = fir_history[j-1];
         else
            tap_in = 0;
         fir += (longint'(cfg_coef[j]) * tap_in) >>> FRAC_W;
      end

      // history update
      lp_prev_out = (lp > OUT_MAX) ? OUT_MAX : ((lp < OUT_MIN) ? OUT_MIN : lp);
      lp_prev_in = x;
      fir_history[2] = fir_history[1];
      fir_history[1] = fir_history[0];
      fir_history[0] = x;
      fir_seen = (hist_valid + 1 > 3) ? 3 : hist_valid + 1;

      y = (cfg_mode == MODE_FIR) ? fir : lp;
      res.sat = 1'b0;
      if (y > OUT_MAX) begin
         y = OUT_MAX;
         res.sat = 1'b1;
      end
      if (y < OUT_MIN) begin
         y = OUT_MIN;
         res.sat = 1'b1;
      end
      res.sample = y[SAMPLE_W-1:0];
      return res;
   endfunction

   // Driver: bursts of random length separated by random gaps
   int burst_left = 8;
   int gap_left = 0;

   always @(posedge clock) begin : req_driver
      logic next_valid;
      sample_item_type item;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outputs.insert(expected_outputs.size(),
                                    predict_filtered(req_tdata, req_tuser[0]));
            samples_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_samples.size() > 0) begin
               item = pending_samples.pop_front();
               req_tdata <= item.sample;
               req_tuser <= item.sos;
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 32);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // Checker and receiver stall pattern
   logic [15:0] stall_tick = '0;
   int hold_left = 0;
   int next_hold_at = 200;

   always @(posedge clock) begin : rsp_monitor
      filtered_type want;
      logic next_ready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser[0])
            clamped_seen++;
         if (expected_outputs.size() == 0) begin
            error_count++;
            $error("result with nothing expected: sample_out %h saturated %b",
                   rsp_tdata, rsp_tuser[0]);
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_tdata !== want.sample) begin
               error_count++;
               $error("sample_out: expected %h, actual %h", want.sample, rsp_tdata);
            end
            if (rsp_tuser[0] !== want.sat) begin
               error_count++;
               $error("saturated: expected %b, actual %b", want.sat, rsp_tuser[0]);
            end
         end
      end

      stall_tick++;
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (holds_done < 2 && results_seen >= next_hold_at &&
                   pending_samples.size() > 40) begin
         // long hold-off so the pipeline fills and back-pressures the input
         hold_left = HOLD_CYCLES;
         holds_done++;
         next_hold_at += 500;
         next_ready = 1'b0;
      end else begin
         case (stall_tick[7:6])
            2'd0: next_ready = 1'b1;
            2'd1: next_ready = 1'($urandom_range(0, 1));
            2'd2: next_ready = (stall_tick[1:0] != 2'd0);
            default: next_ready = ($urandom_range(0, 4) != 0);
         endcase
      end
      rsp_tready <= next_ready;
   end

   // Watchdog: cycles without any transfer on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   initial begin : watchdog
      do @(negedge clock); while (idle_cycles < IDLE_LIMIT);
      $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
      $display("selectable_lowpass_fir_filter_unit_tb: done, errors");
      $finish;
   end

   task automatic queue_sample(input logic [SAMPLE_W-1:0] sample, input logic sos);
      sample_item_type item;
      item.sample = sample;
      item.sos = sos;
      pending_samples.insert(pending_samples.size(), item);
      if (sos)
         sequences_queued++;
   endtask

   // Wait for all queued samples to be filtered and checked, then let the pipe settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         REG_FILTER_MODE:     cfg_mode = value[0];
         REG_SMOOTHING_ALPHA: cfg_alpha = value[ALPHA_W-1:0];
         REG_TAP_COEF_0:      cfg_coef[0] = value;
         REG_TAP_COEF_1:      cfg_coef[1] = value;
         REG_TAP_COEF_2:      cfg_coef[2] = value;
         REG_TAP_COEF_3:      cfg_coef[3] = value;
         default: ;           // unmapped index, write dropped
      endcase
   endtask

   task automatic load_settings(input logic mode, input logic [ALPHA_W-1:0] alpha,
                                input logic [COEF_W-1:0] c0, input logic [COEF_W-1:0] c1,
                                input logic [COEF_W-1:0] c2, input logic [COEF_W-1:0] c3);
      write_register(REG_FILTER_MODE, {{(CSR_DATA_W-1){1'b0}}, mode});
      write_register(REG_SMOOTHING_ALPHA, {1'b0, alpha});
      write_register(REG_TAP_COEF_0, c0);
      write_register(REG_TAP_COEF_1, c1);
      write_register(REG_TAP_COEF_2, c2);
      write_register(REG_TAP_COEF_3, c3);
   endtask

   function automatic logic [COEF_W-1:0] random_coef();
      case ($urandom_range(0, 5))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return COEF_W'($urandom_range(0, 1 << (FRAC_W + 1)));   // 0 .. 2.0, where 2.0 wraps to -2.0
         default: return COEF_W'($urandom());
      endcase
   endfunction

   function automatic logic [ALPHA_W-1:0] random_alpha();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ALPHA_ONE;
         2: return ALPHA_W'($urandom_range(65537, 131071));
         default: return ALPHA_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return $urandom_range(0, 1 << 21) - (1 << 20);
         3, 4: return $urandom_range(0, 1 << 25) - (1 << 24);
         default: return $urandom();
      endcase
   endfunction

   initial begin : stimulus
      int seq_len;
      int queued;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset settings; first sample arrives before any start flag
      queue_sample(32'h0001_2345, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b1);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_NEG1, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b1);
      wait_drained();

      // FIR with largest coefficients, drives the clamp high
      load_settings(MODE_FIR, ALPHA_RESET, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      queue_sample(SAMPLE_MAX, 1'b1);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample('0, 1'b0);
      wait_drained();

      // most negative coefficients
      load_settings(MODE_FIR, ALPHA_RESET, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      queue_sample(SAMPLE_MIN, 1'b1);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_NEG1, 1'b1);
      wait_drained();

      // back to low-pass in mid-sequence, alpha above one is capped
      write_register(REG_FILTER_MODE, {{(CSR_DATA_W-1){1'b0}}, MODE_LOW_PASS});
      write_register(REG_SMOOTHING_ALPHA, {1'b0, ALPHA_TOP});
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(32'h0000_8001, 1'b0);
      wait_drained();

      // alpha zero holds the output; unmapped indexes must not disturb anything
      write_register(REG_SMOOTHING_ALPHA, '0);
      write_register(REG_SPARE_6, COEF_MIN);
      write_register(REG_SPARE_7, 18'h3_FFFF);
      queue_sample(SAMPLE_NEG1, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b1);
      queue_sample(SAMPLE_MIN, 1'b0);
      wait_drained();

      // random phases: new settings each time, start-led sequences with some noise
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_settings(1'($urandom_range(0, 1)), random_alpha(), random_coef(),
                       random_coef(), random_coef(), random_coef());
         if (p == 3)
            write_register($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                           CSR_DATA_W'($urandom()));
         queued = 0;
         while (queued < PHASE_ITEMS) begin
            seq_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
            for (int k = 0; k < seq_len && queued < PHASE_ITEMS; k++) begin
               if (k == 0)
                  queue_sample(random_sample(), $urandom_range(0, 9) != 0);
               else
                  queue_sample(random_sample(), $urandom_range(0, 19) == 0);
               queued++;
            end
         end
         wait_drained();
      end

      if (expected_outputs.size() != 0) begin
         error_count++;
         $error("%0d expected results never arrived", expected_outputs.size());
      end
      $display("covered %0d samples in %0d sequences, %0d register writes, %0d clamped results",
               samples_sent, sequences_queued, csr_writes, clamped_seen);
      $display("receiver held off for %0d long stretches", holds_done);
      if (error_count == 0)
         $display("selectable_lowpass_fir_filter_unit_tb: done, clean");
      else
         $display("selectable_lowpass_fir_filter_unit_tb: done, errors");
      $finish;
   end

endmodule
